FILE: src/vcf_pkg.sv
// ----------------------------------------------------------------------------
// vcf_pkg
// Shared types and constants for the valid-mode 1D convolution filter.
// ----------------------------------------------------------------------------
package vcf_pkg;

  // Fixed field widths
  localparam int TAP_BITS       = 16;
  localparam int BIAS_BITS      = 32;
  localparam int OUT_BITS       = 32;
  localparam int TAP_COUNT_BITS = 3;
  localparam int NUM_TAP_REGS   = 6;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Register indexes (tap registers occupy 0 .. NUM_TAP_REGS-1)
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_COUNT = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BIAS      = 3'd7;

  // Per-cell control
  typedef struct packed {
    logic load;    // input transaction taken this cycle
    logic tap_on;  // this cell's age is inside the kernel length
  } cell_ctrl_t;

endpackage

FILE: src/vcf_cell.sv
// ----------------------------------------------------------------------------
// vcf_cell
// One window cell: unless last, holds one delayed sample, passes it to the
// next cell; registers the product of incoming sample and tap weight.
// ----------------------------------------------------------------------------
module vcf_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter bit LAST        = 1'b0
) (
  input  logic                                          clk,
  input  vcf_pkg::cell_ctrl_t                           ctrl,
  input  logic signed [SAMPLE_BITS-1:0]                 sample_in,
  input  logic signed [vcf_pkg::TAP_BITS-1:0]           weight,
  output logic signed [SAMPLE_BITS-1:0]                 sample_out,
  output logic signed [SAMPLE_BITS+vcf_pkg::TAP_BITS-1:0] product
);

  localparam int PROD_W = SAMPLE_BITS + vcf_pkg::TAP_BITS;

  logic signed [PROD_W-1:0] product_next;

  // Weight the incoming sample, zero when the tap is out of use
  always_comb begin
    if (ctrl.tap_on) begin
      product_next = PROD_W'(sample_in) * PROD_W'(weight);
    end else begin
      product_next = '0;
    end
  end

  // Capture the product with each transaction
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      product <= product_next;
    end
  end

  // Shift the sample on to the neighbor; the oldest cell keeps nothing
  if (LAST) begin : g_last
    assign sample_out = '0;
  end else begin : g_keep
    always_ff @(posedge clk) begin
      if (ctrl.load) begin
        sample_out <= sample_in;
      end
    end
  end

endmodule

FILE: src/vcf_sum.sv
// ----------------------------------------------------------------------------
// vcf_sum
// Two-stage adder tree over the cell products plus bias, with saturation to
// 32 bits and the output register of the result stream.
// ----------------------------------------------------------------------------
module vcf_sum #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_TAPS    = 6
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            prod_valid,
  output logic                                            prod_ready,
  input  logic signed [SAMPLE_BITS+vcf_pkg::TAP_BITS-1:0] products [MAX_TAPS],
  input  logic signed [vcf_pkg::BIAS_BITS-1:0]            bias,
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  output logic [vcf_pkg::OUT_BITS-1:0]                    m_tdata,  // conv_value
  output logic [0:0]                                      m_tuser   // saturated_flag
);

  localparam int PROD_W = SAMPLE_BITS + vcf_pkg::TAP_BITS;
  localparam int WIDE_W = (PROD_W > vcf_pkg::BIAS_BITS) ? PROD_W : vcf_pkg::BIAS_BITS;
  localparam int SUM_W  = WIDE_W + 4;
  localparam int NPAIR  = (MAX_TAPS + 1) / 2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic                     pair_valid;
  logic                     pair_ready;
  logic                     out_ready;
  logic signed [SUM_W-1:0]  pair_next [NPAIR];
  logic signed [SUM_W-1:0]  pair_sum  [NPAIR];
  logic signed [SUM_W-1:0]  bias_sum;
  logic signed [SUM_W-1:0]  total;

  // Stage handshake
  assign out_ready  = !m_tvalid || m_tready;
  assign pair_ready = !pair_valid || out_ready;
  assign prod_ready = pair_ready;

  // Add products in pairs
  for (genvar i = 0; i < NPAIR; i++) begin : g_pair
    if (2 * i + 1 < MAX_TAPS) begin : g_two
      assign pair_next[i] = SUM_W'(products[2*i]) + SUM_W'(products[2*i+1]);
    end else begin : g_one
      assign pair_next[i] = SUM_W'(products[2*i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (pair_ready) begin
      pair_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_ready && prod_valid) begin
      pair_sum <= pair_next;
      bias_sum <= SUM_W'(bias);
    end
  end

  // Final sum of the pairs and the bias
  always_comb begin
    total = bias_sum;
    for (int i = 0; i < NPAIR; i++) begin
      total = total + pair_sum[i];
    end
  end

  // Clip and hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && pair_valid) begin
      priority if (total > SAT_HI) begin
        m_tdata <= vcf_pkg::OUT_BITS'(SAT_HI);
        m_tuser <= 1'b1;
      end else if (total < SAT_LO) begin
        m_tdata <= vcf_pkg::OUT_BITS'(SAT_LO);
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= vcf_pkg::OUT_BITS'(total);
        m_tuser <= 1'b0;
      end
    end
  end

endmodule

FILE: src/valid_conv1d_filter.sv
// ----------------------------------------------------------------------------
// valid_conv1d_filter
// Streaming valid-mode 1D convolution with bias, Q4.12 in, Q8.24 out.
// ----------------------------------------------------------------------------
// Takes one sample per clock while s_tready is high and, once the clamped
// tap_count samples of the current vector have arrived (a set tuser bit
// opens a vector), gives one result per sample: bias_value plus the taps
// times the last tap_count samples, tap 0 weighting the oldest, saturated
// to signed 32 bits with a clip flag in tuser. Samples that do not complete
// a window give no result. A result is registered in turn in the cell
// multipliers, the pairwise adders and the final adder and clip stage, so
// the stream runs at one item per cycle whenever the output side keeps
// taking results. Configuration is written through a separate channel
// that is always ready; write it only while the stream is idle.
module valid_conv1d_filter #(
  parameter int MAX_TAPS    = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input samples
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample_value
  input  logic [0:0]                            s_tuser,   // vector_start
  // results
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [vcf_pkg::OUT_BITS-1:0]          m_tdata,   // conv_value
  output logic [0:0]                            m_tuser,   // saturated_flag
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vcf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [vcf_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int PROD_W = SAMPLE_BITS + vcf_pkg::TAP_BITS;
  localparam int FILL_W = $clog2(MAX_TAPS + 1);
  localparam int TC_W   = vcf_pkg::TAP_COUNT_BITS;

  logic signed [vcf_pkg::TAP_BITS-1:0]  tap_reg [vcf_pkg::NUM_TAP_REGS];
  logic [TC_W-1:0]                      tap_count;
  logic signed [vcf_pkg::BIAS_BITS-1:0] bias_value;

  logic [FILL_W-1:0]        fill_count;
  logic [FILL_W-1:0]        fill_count_next;
  logic [FILL_W-1:0]        prev_count;
  logic [TC_W:0]            prev_plus;
  logic [TC_W-1:0]          taps_used;
  logic                     produce;
  logic                     accept;
  logic                     prod_valid;
  logic                     prod_ready;

  logic signed [SAMPLE_BITS-1:0] sample_chain [MAX_TAPS+1];
  logic signed [PROD_W-1:0]      products     [MAX_TAPS];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vcf_pkg::NUM_TAP_REGS; i++) begin
        tap_reg[i] <= '0;
      end
      tap_count  <= TC_W'(1);
      bias_value <= '0;
    end else if (cfg_valid) begin
      priority if (cfg_index < vcf_pkg::CFG_INDEX_BITS'(vcf_pkg::NUM_TAP_REGS)) begin
        tap_reg[cfg_index] <= cfg_data[vcf_pkg::TAP_BITS-1:0];
      end else if (cfg_index == vcf_pkg::REG_TAP_COUNT) begin
        tap_count <= cfg_data[TC_W-1:0];
      end else if (cfg_index == vcf_pkg::REG_BIAS) begin
        bias_value <= cfg_data[vcf_pkg::BIAS_BITS-1:0];
      end
    end
  end

  // Clamp the kernel length to 1 .. MAX_TAPS
  always_comb begin
    priority if (tap_count == '0) begin
      taps_used = TC_W'(1);
    end else if (tap_count > TC_W'(MAX_TAPS)) begin
      taps_used = TC_W'(MAX_TAPS);
    end else begin
      taps_used = tap_count;
    end
  end

  // Track how much of the current vector sits in the window
  assign accept     = s_tvalid && s_tready;
  assign prev_count = s_tuser[0] ? '0 : fill_count;
  assign prev_plus  = (TC_W + 1)'(prev_count) + (TC_W + 1)'(1);
  assign produce    = prev_plus >= (TC_W + 1)'(taps_used);

  always_comb begin
    if (prev_plus > (TC_W + 1)'(MAX_TAPS - 1)) begin
      fill_count_next = FILL_W'(MAX_TAPS - 1);
    end else begin
      fill_count_next = FILL_W'(prev_plus);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
    end
  end

  // Product stage valid
  assign s_tready = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= s_tvalid && produce;
    end
  end

  // Row of window cells, cell j sees the sample j steps back
  assign sample_chain[0] = s_tdata[SAMPLE_BITS-1:0];

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    vcf_pkg::cell_ctrl_t                 ctrl;
    logic signed [vcf_pkg::TAP_BITS-1:0] weight;
    logic [TC_W-1:0]                     tap_sel;

    assign ctrl.load   = accept;
    assign ctrl.tap_on = TC_W'(j) < taps_used;
    assign tap_sel     = taps_used - TC_W'(1) - TC_W'(j);

    always_comb begin
      if (ctrl.tap_on) begin
        weight = tap_reg[tap_sel];
      end else begin
        weight = '0;
      end
    end

    vcf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LAST        (j == MAX_TAPS - 1)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .sample_in  (sample_chain[j]),
      .weight     (weight),
      .sample_out (sample_chain[j+1]),
      .product    (products[j])
    );
  end

  // Adder tree, clip and output register
  vcf_sum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TAPS    (MAX_TAPS)
  ) u_sum (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .products   (products),
    .bias       (bias_value),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

FILE: src/vcf_checker.sv
// ----------------------------------------------------------------------------
// vcf_checker
// Port-level checks on the filter's result stream and input flow control.
// ----------------------------------------------------------------------------
module vcf_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [vcf_pkg::OUT_BITS-1:0] m_tdata,
  input logic [0:0]                   m_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Flag a clip only on a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
    else $error("clip flag without rail value");

  // Take input whenever the output register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Come out of reset with no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind valid_conv1d_filter vcf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_vcf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
